// ===== hw/rtl/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
`default_nettype none

package wsd_pkg;

  localparam int LENGTH_BITS = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_CLOSE   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } wsd_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsd_front.sv =====
// header parser: tracks frame state and classifies each stream word
`default_nettype none

module wsd_front import wsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output wsd_entry_t      push_ent
);

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXT    = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CLOSED = 3'd5
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   frame_fin, frame_fin_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic                   masked, masked_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [2:0]             ext_count, ext_count_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_pos, mask_pos_next;

  always_comb begin
    logic [LENGTH_BITS-1:0] rem_shift;
    logic [6:0]             len7;
    phase_next        = phase;
    frame_fin_next    = frame_fin;
    frame_opcode_next = frame_opcode;
    masked_next       = masked;
    remaining_next    = remaining;
    ext_count_next    = ext_count;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    rem_shift         = {remaining[LENGTH_BITS-9:0], in_byte};
    len7              = in_byte[6:0];
    push              = 1'b0;
    push_ent.kind     = KIND_PAYLOAD;
    push_ent.data     = 8'd0;
    push_ent.key      = 8'd0;
    push_ent.opcode   = frame_opcode;
    push_ent.fin      = frame_fin;
    push_ent.last     = 1'b1;
    unique case (phase)
      PH_HDR1: begin
        if (frame_opcode == OP_CLOSE) begin
          phase_next    = PH_CLOSED;
          push          = 1'b1;
          push_ent.kind = KIND_CLOSE;
        end else begin
          masked_next = in_byte[7];
          if (len7 == LEN_EXT16) begin
            remaining_next = '0;
            ext_count_next = 3'd1;
            phase_next     = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            remaining_next = '0;
            ext_count_next = 3'd7;
            phase_next     = PH_EXT;
          end else begin
            remaining_next = LENGTH_BITS'(len7);
            mask_pos_next  = 2'd0;
            if (in_byte[7]) begin
              phase_next = PH_KEY;
            end else if (len7 == 7'd0) begin
              phase_next    = PH_HDR0;
              push          = 1'b1;
              push_ent.kind = KIND_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
      end
      PH_EXT: begin
        remaining_next = rem_shift;
        if (ext_count != 3'd0) begin
          ext_count_next = ext_count - 3'd1;
        end else begin
          mask_pos_next = 2'd0;
          if (masked) begin
            phase_next = PH_KEY;
          end else if (rem_shift == '0) begin
            phase_next    = PH_HDR0;
            push          = 1'b1;
            push_ent.kind = KIND_EMPTY;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        mask_pos_next = mask_pos + 2'd1;
        if (mask_pos == 2'd3) begin
          if (remaining == '0) begin
            phase_next    = PH_HDR0;
            push          = 1'b1;
            push_ent.kind = KIND_EMPTY;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        push           = 1'b1;
        push_ent.data  = in_byte;
        push_ent.key   = masked ? mask_key[{~mask_pos, 3'b000} +: 8] : 8'd0;
        push_ent.last  = (remaining == LENGTH_BITS'(1));
        remaining_next = remaining - LENGTH_BITS'(1);
        mask_pos_next  = mask_pos + 2'd1;
        if (remaining == LENGTH_BITS'(1)) begin
          phase_next    = PH_HDR0;
          mask_pos_next = 2'd0;
        end
      end
      PH_CLOSED: begin
        phase_next = PH_CLOSED;
      end
      default: begin
        frame_fin_next    = in_byte[7];
        frame_opcode_next = in_byte[3:0];
        phase_next        = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      frame_fin    <= 1'b0;
      frame_opcode <= 4'd0;
      masked       <= 1'b0;
      remaining    <= '0;
      ext_count    <= 3'd0;
      mask_key     <= 32'd0;
      mask_pos     <= 2'd0;
    end else if (accept) begin
      phase        <= phase_next;
      frame_fin    <= frame_fin_next;
      frame_opcode <= frame_opcode_next;
      masked       <= masked_next;
      remaining    <= remaining_next;
      ext_count    <= ext_count_next;
      mask_key     <= mask_key_next;
      mask_pos     <= mask_pos_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_queue.sv =====
// two-entry queue between the header parser and the output stage
`default_nettype none

module wsd_queue import wsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire wsd_entry_t  push_ent,
  input  wire logic        pop,
  output logic             full,
  output logic             not_empty,
  output wsd_entry_t       head
);

  logic [QCOUNT_W-1:0] count;
  wsd_entry_t          slot0, slot1;

  assign full      = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + QCOUNT_W'(1);
        2'b01:   count <= count - QCOUNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((count == '0) || ((count == QCOUNT_W'(1)) && pop))) begin
      slot0 <= push_ent;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && (count == QCOUNT_W'(1)) && !pop) begin
      slot1 <= push_ent;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_back.sv =====
// output stage: unmasks payload words and holds the result register
`default_nettype none

module wsd_back import wsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire wsd_entry_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic [3:0]      opcode,
  output logic            fin,
  output logic            last
);

  assign pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind     <= q_head.kind;
      out_byte <= q_head.data ^ q_head.key;
      opcode   <= q_head.opcode;
      fin      <= q_head.fin;
      last     <= q_head.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer
// Takes one stream word per clock with no bubbles: a word is accepted every cycle that in_valid
// is high and in_stall is low, and in_stall rises only when the two-entry result queue is full
// because the output side is stalling. The per-word frame state update in the header parser is
// the step that sets this rate. A result enters the result queue when its word is accepted and
// passes from there into the output register. Header, extended-length and key words give no
// payload byte; each payload word gives one unmasked byte, a zero-length frame one empty marker,
// and a close frame one close marker, after which all words are dropped until reset.
`default_nettype none

module websocket_frame_deframer import wsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic [3:0]      opcode,
  output logic            fin,
  output logic            last
);

  logic       accept;
  logic       push;
  wsd_entry_t push_ent;
  logic       q_full;
  logic       q_valid;
  wsd_entry_t q_head;
  logic       pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  wsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .push     (push),
    .push_ent (push_ent)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push && accept),
    .push_ent  (push_ent),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  wsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .opcode    (opcode),
    .fin       (fin),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_checker.sv =====
// port-level checks for the websocket frame deframer and their binding
`default_nettype none

module wsd_checker import wsd_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] kind,
  input wire logic [7:0] out_byte,
  input wire logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte) && $stable(last))
    else $error("stalled result changed");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_PAYLOAD) || (kind == KIND_EMPTY) || (kind == KIND_CLOSE))
    else $error("undefined result kind");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_PAYLOAD) |-> last && (out_byte == 8'd0))
    else $error("marker without last or with nonzero byte");

  a_close_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (kind == KIND_CLOSE) |=> !out_valid)
    else $error("result after close marker");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .out_byte  (out_byte),
  .last      (last)
);

`default_nettype wire
